@@ hdl/tile_record_byte_parser_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the tile record byte parser
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef TILE_RECORD_BYTE_PARSER_ASSERT_SVH
`define TILE_RECORD_BYTE_PARSER_ASSERT_SVH

`ifndef ASSERT_OFF
// Property must hold at every clock edge out of reset
`define TRBP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("tile record byte parser assertion failed");
// Condition must never be true at a clock edge out of reset
`define TRBP_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("tile record byte parser forbidden condition");
`else
`define TRBP_ASSERT(lbl, prop)
`define TRBP_ASSERT_NEVER(lbl, cond)
`endif

`endif

@@ hdl/trbp_pkg.sv @@
// ----------------------------------------------------------------------------
// Tile record byte parser package
// Item types, parse phases and the record part sequencing function.
// ----------------------------------------------------------------------------
package trbp_pkg;

  localparam int TableBytes = 128;
  localparam int TableAddrW = 7;

  // Header byte bits
  localparam int HdrChainBit  = 0;
  localparam int HdrActiveBit = 1;
  localparam int HdrWallBit   = 2;
  localparam int HdrWideType  = 5;

  // Liquid codes in header bits 4..3
  localparam logic [1:0] LiqLava  = 2'd2;
  localparam logic [1:0] LiqHoney = 2'd3;

  // Run length codes in header bits 7..6
  localparam logic [1:0] RunByte = 2'd1;
  localparam logic [1:0] RunWord = 2'd2;

  // Third flag byte bits
  localparam int F3ActuatorBit  = 1;
  localparam int F3InactiveBit  = 2;
  localparam int F3TilePaintBit = 3;
  localparam int F3WallPaintBit = 4;

  typedef enum logic [3:0] {
    PH_HDR    = 4'd0,
    PH_F2     = 4'd1,
    PH_F3     = 4'd2,
    PH_TLO    = 4'd3,
    PH_THI    = 4'd4,
    PH_ULO    = 4'd5,
    PH_UHI    = 4'd6,
    PH_VLO    = 4'd7,
    PH_VHI    = 4'd8,
    PH_TPAINT = 4'd9,
    PH_WALL   = 4'd10,
    PH_WPAINT = 4'd11,
    PH_LIQ    = 4'd12,
    PH_RLO    = 4'd13,
    PH_RHI    = 4'd14,
    PH_DONE   = 4'd15
  } phase_e;

  typedef struct packed {
    logic                  mode;
    logic [7:0]            data_byte;
    logic [TableAddrW-1:0] table_addr;
  } in_item_t;

  typedef struct packed {
    logic [15:0] tile_type;
    logic        frame_present;
    logic [15:0] frame_u;
    logic [15:0] frame_v;
    logic [7:0]  tile_paint;
    logic [7:0]  wall_type;
    logic [7:0]  wall_paint;
    logic [7:0]  liquid_amount;
    logic [8:0]  tile_flags;
    logic [2:0]  slope_kind;
    logic [15:0] run_length;
  } res_item_t;

  // Parse state the front end needs to address the frame table
  typedef struct packed {
    phase_e     phase;
    logic [7:0] type_lo;
  } issue_t;

  // Pick the first record part after 'from' that the flags call for
  function automatic phase_e next_phase(phase_e from, logic [7:0] hdr, logic [7:0] f2,
                                        logic [7:0] f3, logic framed);
    logic [15:0] need;
    logic        active;
    logic        found;
    phase_e      nxt;
    active = hdr[HdrActiveBit];
    need   = '0;
    need[PH_F2]     = hdr[HdrChainBit];
    need[PH_F3]     = hdr[HdrChainBit] & f2[0];
    need[PH_TLO]    = active;
    need[PH_THI]    = active & hdr[HdrWideType];
    need[PH_ULO]    = active & framed;
    need[PH_UHI]    = active & framed;
    need[PH_VLO]    = active & framed;
    need[PH_VHI]    = active & framed;
    need[PH_TPAINT] = active & f3[F3TilePaintBit];
    need[PH_WALL]   = hdr[HdrWallBit];
    need[PH_WPAINT] = hdr[HdrWallBit] & f3[F3WallPaintBit];
    need[PH_LIQ]    = hdr[4:3] != 2'd0;
    need[PH_RLO]    = (hdr[7:6] == RunByte) || (hdr[7:6] == RunWord);
    need[PH_RHI]    = hdr[7:6] == RunWord;
    found = 1'b0;
    nxt   = PH_DONE;
    for (int p = 1; p < 15; p++) begin
      if (!found && (4'(p) > from) && need[p]) begin
        found = 1'b1;
        nxt   = phase_e'(4'(p));
      end
    end
    return nxt;
  endfunction

endpackage

@@ hdl/trbp_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data and read enable.
// ----------------------------------------------------------------------------
module trbp_ram #(
  parameter int Width = 8,
  parameter int Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/trbp_parse.sv @@
// ----------------------------------------------------------------------------
// Record parse state
// Applies one byte to the record state, sequences the record parts and
// builds the result when a record completes.
// ----------------------------------------------------------------------------
module trbp_parse #(
  parameter int TYPE_COUNT = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  trbp_pkg::in_item_t item_i,
  input  logic [7:0]         rd_data_i,
  output trbp_pkg::issue_t   issue_o,
  output logic               emit_o,
  output trbp_pkg::res_item_t result_o
);

  import trbp_pkg::*;

  // Types at or above this bound are never framed
  localparam int          TypeBound = (TYPE_COUNT < 1024) ? TYPE_COUNT : 1024;
  localparam logic [16:0] TypeLimit = 17'(TypeBound);

  phase_e      phase_q, phase_d;
  logic [7:0]  hdr_q, hdr_d;
  logic [7:0]  f2_q, f2_d;
  logic [7:0]  f3_q, f3_d;
  logic [7:0]  lo_q, lo_d;
  logic [15:0] type_q, type_d;
  logic [15:0] u_q, u_d;
  logic [15:0] v_q, v_d;
  logic [7:0]  tpaint_q, tpaint_d;
  logic [7:0]  wall_q, wall_d;
  logic [7:0]  wpaint_q, wpaint_d;
  logic [7:0]  liq_q, liq_d;
  logic [15:0] run_q, run_d;
  logic        framed_q, framed_d;
  phase_e      nxt;
  logic        framed_out;
  logic [2:0]  slope;
  logic [7:0]  b;

  assign b = item_i.data_byte;

  // Apply the held byte to the record state; emit tells whether it closes a record
  always_comb begin
    phase_d  = phase_q;
    hdr_d    = hdr_q;
    f2_d     = f2_q;
    f3_d     = f3_q;
    lo_d     = lo_q;
    type_d   = type_q;
    u_d      = u_q;
    v_d      = v_q;
    tpaint_d = tpaint_q;
    wall_d   = wall_q;
    wpaint_d = wpaint_q;
    liq_d    = liq_q;
    run_d    = run_q;
    framed_d = framed_q;
    emit_o   = 1'b0;
    nxt      = PH_DONE;
    if (item_i.mode) begin
      // Table load: follow a change to the current type's framed bit
      if ((item_i.table_addr == type_q[9:3]) && ({1'b0, type_q} < TypeLimit)) begin
        framed_d = b[type_q[2:0]];
      end
    end else begin
      case (phase_q)
        PH_HDR: begin
          hdr_d    = b;
          f2_d     = '0;
          f3_d     = '0;
          type_d   = '0;
          u_d      = '0;
          v_d      = '0;
          tpaint_d = '0;
          wall_d   = '0;
          wpaint_d = '0;
          liq_d    = '0;
          run_d    = '0;
        end
        PH_F2:     f2_d = b;
        PH_F3:     f3_d = b;
        PH_TLO:    type_d[7:0] = b;
        PH_THI:    type_d[15:8] = b;
        PH_ULO:    lo_d = b;
        PH_VLO:    lo_d = b;
        PH_RLO: begin
          lo_d  = b;
          run_d = {8'h00, b};
        end
        PH_UHI:    u_d = {b, lo_q};
        PH_VHI:    v_d = {b, lo_q};
        PH_TPAINT: tpaint_d = b;
        PH_WALL:   wall_d = b;
        PH_WPAINT: wpaint_d = b;
        PH_LIQ:    liq_d = b;
        PH_RHI:    run_d = {b, lo_q};
        default:   hdr_d = hdr_q;
      endcase
      // Frame table data was read for this byte at its transfer
      if ((phase_q == PH_TLO) || (phase_q == PH_THI)) begin
        framed_d = ({1'b0, type_d} < TypeLimit) && rd_data_i[type_d[2:0]];
      end
      nxt = next_phase(phase_q, hdr_d, f2_d, f3_d, framed_d);
      if (nxt == PH_DONE) begin
        emit_o  = 1'b1;
        phase_d = PH_HDR;
      end else begin
        phase_d = nxt;
      end
    end
  end

  // Hold the record state; advance it on a step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HDR;
      hdr_q    <= '0;
      f2_q     <= '0;
      f3_q     <= '0;
      lo_q     <= '0;
      type_q   <= '0;
      u_q      <= '0;
      v_q      <= '0;
      tpaint_q <= '0;
      wall_q   <= '0;
      wpaint_q <= '0;
      liq_q    <= '0;
      run_q    <= '0;
      framed_q <= 1'b0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      hdr_q    <= hdr_d;
      f2_q     <= f2_d;
      f3_q     <= f3_d;
      lo_q     <= lo_d;
      type_q   <= type_d;
      u_q      <= u_d;
      v_q      <= v_d;
      tpaint_q <= tpaint_d;
      wall_q   <= wall_d;
      wpaint_q <= wpaint_d;
      liq_q    <= liq_d;
      run_q    <= run_d;
      framed_q <= framed_d;
    end
  end

  // Phase and type low byte of the next byte, for the table read address
  assign issue_o.phase   = step_i ? phase_d : phase_q;
  assign issue_o.type_lo = step_i ? type_d[7:0] : type_q[7:0];

  // Build the result from the updated record
  assign framed_out = hdr_d[HdrActiveBit] & framed_d;
  assign slope      = f2_d[6:4];

  always_comb begin
    result_o.tile_type     = type_d;
    result_o.frame_present = framed_out;
    result_o.frame_u       = framed_out ? u_d : 16'h0000;
    result_o.frame_v       = framed_out ? v_d : 16'h0000;
    result_o.tile_paint    = tpaint_d;
    result_o.wall_type     = wall_d;
    result_o.wall_paint    = wpaint_d;
    result_o.liquid_amount = liq_d;
    result_o.tile_flags    = {f3_d[F3InactiveBit], f3_d[F3ActuatorBit], slope == 3'd1,
                              f2_d[3:1], hdr_d[4:3] == LiqHoney, hdr_d[4:3] == LiqLava,
                              hdr_d[HdrActiveBit]};
    result_o.slope_kind    = (slope > 3'd1) ? slope - 3'd1 : 3'd0;
    result_o.run_length    = run_d;
  end

endmodule

@@ hdl/tile_record_byte_parser.sv @@
// A result is loaded into the output register from the input stage that holds the byte completing its record.
// Throughput: one byte per cycle, stream or table load; output stall backs up the input.
// The frame table read is issued at the byte's transfer and is ready in the input stage.
// Reset clears the parse state and both stages; the frame table holds garbage until loaded.
// ----------------------------------------------------------------------------
// Tile record byte parser
// Input stage, record parse state, frame table RAM and output register.
// ----------------------------------------------------------------------------
`include "tile_record_byte_parser_assert.svh"

module tile_record_byte_parser #(
  parameter int TYPE_COUNT = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  trbp_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output trbp_pkg::res_item_t out_data_o
);

  import trbp_pkg::*;

  logic                  accept;
  logic                  advance;
  logic                  s1_valid_q, s1_valid_d;
  in_item_t              s1_item_q;
  logic [7:0]            rd_data;
  logic                  rd_en;
  logic [TableAddrW-1:0] rd_addr;
  issue_t                issue;
  logic                  emit;
  res_item_t             result;
  logic                  out_load;
  logic                  out_valid_q, out_valid_d;
  res_item_t             out_data_q;

  // Input stage moves on unless a result would overrun a stalled output
  assign advance    = s1_valid_q && !(emit && out_valid_q && out_stall_i);
  assign in_stall_o = s1_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;
  assign s1_valid_d = accept | (s1_valid_q & !advance);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_item_q <= in_data_i;
    end
  end

  // Address the table byte covering the type this byte completes
  assign rd_en   = accept && !in_data_i.mode;
  assign rd_addr = (issue.phase == PH_THI) ? {in_data_i.data_byte[1:0], issue.type_lo[7:3]}
                                           : {2'b00, in_data_i.data_byte[7:3]};

  trbp_ram #(
    .Width(8),
    .Depth(TableBytes)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (accept && in_data_i.mode),
    .waddr_i(in_data_i.table_addr),
    .wdata_i(in_data_i.data_byte),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(rd_data)
  );

  trbp_parse #(
    .TYPE_COUNT(TYPE_COUNT)
  ) u_parse (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (s1_item_q),
    .rd_data_i(rd_data),
    .issue_o  (issue),
    .emit_o   (emit),
    .result_o (result)
  );

  // Output register: load a finished record, drop it once transferred
  assign out_load    = advance && emit;
  assign out_valid_d = out_load | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Input stalls only behind a full, stalled output register
  `TRBP_ASSERT(a_stall_cause, in_stall_o |-> (out_valid_o && out_stall_i))
  // A table load never completes a record
  `TRBP_ASSERT_NEVER(a_load_no_emit, s1_valid_q && s1_item_q.mode && emit)
  // A transferred result is dropped unless a new one loads
  `TRBP_ASSERT(a_out_drain, (out_valid_o && !out_stall_i && !out_load) |=> !out_valid_o)

endmodule
